// File: hdl/hen_pkg.sv
`default_nettype none

package hen_pkg;

    localparam int TAPS        = 128;
    localparam int HALF_ROM    = 64;
    localparam int SECTIONS    = 2;
    localparam int SAMPLE_BITS = 16;

    localparam int ADDR_W = $clog2(TAPS);
    localparam int FILL_W = $clog2(TAPS + 1);
    localparam int CNT_W  = $clog2(TAPS + 2);
    localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int BQ_W   = 48;
    localparam int BQ_N   = 2 * SECTIONS;
    localparam int ACC_W  = 40;
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    localparam int DELAY_AGE  = TAPS / 2 - 1;
    localparam int CONV_SHIFT = SAMPLE_BITS - 8;
    localparam int DLY_SHIFT  = 2 * (25 - SAMPLE_BITS);
    localparam int ENV_SHIFT  = 53 - SAMPLE_BITS;

    localparam logic [32:0] GAIN_Q60 = 33'd7083126463;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_GAIN = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ENV_MODE    = 1'd1;
    localparam logic [15:0] GAIN_RESET = 16'd4096;

    function automatic logic [16:0] hen_tap(input logic [5:0] idx);
        logic [16:0] t;
        case (idx)
            6'd0:  t = 17'd17770;  6'd1:  t = 17'd60;    6'd2:  t = 17'd1170;
            6'd3:  t = 17'd67;     6'd4:  t = 17'd1212;  6'd5:  t = 17'd75;
            6'd6:  t = 17'd1257;   6'd7:  t = 17'd84;    6'd8:  t = 17'd1304;
            6'd9:  t = 17'd93;     6'd10: t = 17'd1351;  6'd11: t = 17'd102;
            6'd12: t = 17'd1394;   6'd13: t = 17'd114;   6'd14: t = 17'd1426;
            6'd15: t = 17'd163;    6'd16: t = 17'd1501;  6'd17: t = 17'd169;
            6'd18: t = 17'd1548;   6'd19: t = 17'd198;   6'd20: t = 17'd1605;
            6'd21: t = 17'd232;    6'd22: t = 17'd1666;  6'd23: t = 17'd271;
            6'd24: t = 17'd1731;   6'd25: t = 17'd317;   6'd26: t = 17'd1801;
            6'd27: t = 17'd365;    6'd28: t = 17'd1877;  6'd29: t = 17'd413;
            6'd30: t = 17'd1961;   6'd31: t = 17'd488;   6'd32: t = 17'd2052;
            6'd33: t = 17'd561;    6'd34: t = 17'd2154;  6'd35: t = 17'd648;
            6'd36: t = 17'd2268;   6'd37: t = 17'd751;   6'd38: t = 17'd2398;
            6'd39: t = 17'd872;    6'd40: t = 17'd2550;  6'd41: t = 17'd1018;
            6'd42: t = 17'd2726;   6'd43: t = 17'd1195;  6'd44: t = 17'd2931;
            6'd45: t = 17'd1407;   6'd46: t = 17'd3188;  6'd47: t = 17'd1546;
            6'd48: t = 17'd3504;   6'd49: t = 17'd2023;  6'd50: t = 17'd3911;
            6'd51: t = 17'd2480;   6'd52: t = 17'd4456;  6'd53: t = 17'd3114;
            6'd54: t = 17'd5225;   6'd55: t = 17'd4048;  6'd56: t = 17'd6404;
            6'd57: t = 17'd5558;   6'd58: t = 17'd8434;  6'd59: t = 17'd8410;
            6'd60: t = 17'd12770;  6'd61: t = 17'd15829; 6'd62: t = 17'd28668;
            default: t = 17'd82586;
        endcase
        return t;
    endfunction

    function automatic logic signed [31:0] hen_fb(input logic sec, input logic second);
        logic signed [31:0] c;
        case ({sec, second})
            2'b00:   c = -32'sd2112388085;
            2'b01:   c = 32'sd1038981304;
            2'b10:   c = -32'sd2132609285;
            default: c = 32'sd1059205716;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/hen_ram.sv
`default_nettype none

module hen_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/hilbert_envelope_noise_modulator.sv
`default_nettype none
// Hilbert envelope noise modulator.
// The input channel (in_valid, in_stall) carries one audio sample and one noise
// sample per transfer. The output channel (out_valid, out_stall) carries one
// saturated sample per input transfer, in order.
// The block works on one item at a time. An item passes through the 128-tap
// Hilbert filter, one tap per cycle through the single shared multiplier and
// the window RAM port, then the bit-pair square root, the two biquad sections
// and the output scaling, which also reuse that multiplier. in_stall is high
// for the whole time an item is in work.
// The finished result sits in an output register, so a new item is accepted
// while the previous result waits. If the receiver stalls and a second result
// is ready, the block holds that result and keeps in_stall high until the
// output register is free.
// The configuration port is to be written only while the block is idle; the block itself does not enforce this.
// Reset empties the sample window by clearing its fill count, clears the filter
// states and the output valid, loads output_gain with 1.0 and clears the envelope mode flag.

module hilbert_envelope_noise_modulator (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire logic signed [hen_pkg::SAMPLE_BITS-1:0]  audio_in,
    input  wire logic signed [hen_pkg::SAMPLE_BITS-1:0]  noise_in,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic signed [hen_pkg::SAMPLE_BITS-1:0]       audio_out,
    input  wire logic                                    cfg_we,
    input  wire logic [hen_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  wire logic [hen_pkg::CFG_DATA_W-1:0]          cfg_data
);

    import hen_pkg::*;

    typedef enum logic [22:0] {
        S_IDLE = 23'h000001,
        S_FIR  = 23'h000002,
        S_SQD  = 23'h000004,
        S_SQC  = 23'h000008,
        S_SQS  = 23'h000010,
        S_SQRT = 23'h000020,
        S_GAIN = 23'h000040,
        S_GX   = 23'h000080,
        S_BY   = 23'h000100,
        S_BM1  = 23'h000200,
        S_BM2  = 23'h000400,
        S_BM3  = 23'h000800,
        S_BM4  = 23'h001000,
        S_BM5  = 23'h002000,
        S_BUPD = 23'h004000,
        S_O1   = 23'h008000,
        S_O2   = 23'h010000,
        S_O3   = 23'h020000,
        S_O4   = 23'h040000,
        S_O5   = 23'h080000,
        S_O6   = 23'h100000,
        S_O7   = 23'h200000,
        S_OUT  = 23'h400000
    } state_t;

    localparam int SB = SAMPLE_BITS;
    localparam logic [63:0] MAXV = 64'((64'd1 << (SB - 1)) - 64'd1);

    function automatic logic [SB-1:0] mag_of(input logic [SB-1:0] v);
        return v[SB-1] ? SB'(-v) : v;
    endfunction

    function automatic logic signed [BQ_W-1:0] sat48(input logic signed [53:0] v);
        logic signed [53:0] hi;
        logic signed [53:0] lo;
        hi = 54'sd140737488355327;
        lo = -54'sd140737488355328;
        if (v > hi)
        begin
            return BQ_W'(hi);
        end
        else if (v < lo)
        begin
            return BQ_W'(lo);
        end
        return v[BQ_W-1:0];
    endfunction

    function automatic logic [SB-1:0] sat_out(input logic neg, input logic [63:0] r);
        logic [63:0] v;
        if (neg)
        begin
            v = (r > MAXV + 64'd1) ? MAXV + 64'd1 : r;
            return SB'(-v[SB-1:0]);
        end
        v = (r > MAXV) ? MAXV : r;
        return v[SB-1:0];
    endfunction

    state_t state_reg;

    logic [15:0]          gain_reg;
    logic                 env_only_reg;

    logic [ADDR_W-1:0]    wp_reg;
    logic [ADDR_W-1:0]    cur_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 rd_ok_reg;
    logic                 s2_reg;
    logic                 tneg_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [SB-1:0]        noise_reg;
    logic [SB-1:0]        dly_reg;
    logic [31:0]          conv_reg;
    logic [63:0]          sqa_reg;
    logic [63:0]          sq_v_reg;
    logic [63:0]          sq_r_reg;
    logic [63:0]          bit_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [63:0]          pl_reg;
    logic signed [BQ_W-1:0] x_reg;
    logic signed [BQ_W-1:0] y_reg;
    logic signed [51:0]   q1_reg;
    logic signed [51:0]   q2_reg;
    logic signed [BQ_W-1:0] bq_reg [BQ_N];
    logic [SEC_W-1:0]     sec_reg;
    logic [63:0]          m_reg;
    logic [38:0]          t_reg;
    logic [SB-1:0]        res_reg;
    logic                 out_valid_reg;
    logic [SB-1:0]        audio_out_reg;

    logic                 in_xfer;
    logic                 out_xfer;
    logic [SB-1:0]        rdata;
    logic [ADDR_W-1:0]    raddr;
    logic [ADDR_W-1:0]    age;
    logic [ADDR_W-1:0]    j1;
    logic [5:0]           tap_idx;
    logic                 st1_act;
    logic [MUL_W-1:0]     mul_a;
    logic [MUL_W-1:0]     mul_b;
    logic [63:0]          trial;
    logic [47:0]          ay;
    logic                 y_neg;
    logic                 sec_sel;
    logic signed [31:0]   a1;
    logic signed [31:0]   a2;
    logic [31:0]          a1_mag;
    logic [31:0]          a2_mag;
    logic [63:0]          ph;
    logic [63:0]          rnd_sum;
    logic [63:0]          q_mag;
    logic [ACC_W-1:0]     acc_mag;
    logic [SB-1:0]        noise_mag;
    logic [64:0]          env_round;
    logic [64:0]          t_round;
    logic [63:0]          tu;
    logic [63:0]          tu_round;
    logic signed [53:0]   st0_next;
    logic signed [53:0]   st1_next;
    logic signed [53:0]   y_sum;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign audio_out = audio_out_reg;
    assign out_xfer  = out_valid_reg && !out_stall;

    hen_ram #(
        .WIDTH (SB),
        .DEPTH (TAPS)
    ) u_window (
        .clk   (clk),
        .we    (in_xfer),
        .waddr (wp_reg),
        .wdata (audio_in),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        if (cnt_reg < CNT_W'(TAPS))
        begin
            age = ~cnt_reg[ADDR_W-1:0];
        end
        else
        begin
            age = ADDR_W'(DELAY_AGE);
        end
        raddr   = cur_reg - age;
        j1      = ADDR_W'(cnt_reg - CNT_W'(1));
        tap_idx = j1[ADDR_W-1] ? ~j1[5:0] : j1[5:0];
        st1_act = (state_reg == S_FIR) && (cnt_reg != '0) && (cnt_reg <= CNT_W'(TAPS));
    end

    always_comb
    begin
        y_neg     = y_reg[BQ_W-1];
        ay        = y_neg ? 48'(-y_reg) : 48'(y_reg);
        sec_sel   = (sec_reg < SEC_W'(1)) ? 1'b0 : 1'b1;
        a1        = hen_fb(sec_sel, 1'b0);
        a2        = hen_fb(sec_sel, 1'b1);
        a1_mag    = a1[31] ? 32'(-a1) : 32'(a1);
        a2_mag    = a2[31] ? 32'(-a2) : 32'(a2);
        noise_mag = mag_of(noise_reg);
        acc_mag   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        trial     = sq_r_reg + bit_reg;
        ph        = prod_reg[63:0];
        rnd_sum   = 64'({ph[5:0], 24'd0}) + pl_reg + (64'd1 << 29);
        q_mag     = (ph >> 6) + (rnd_sum >> 30);
        env_round = 65'(m_reg) + (65'd1 << (ENV_SHIFT - 1));
        t_round   = 65'(m_reg) + (65'd1 << 24);
        tu        = 64'({prod_reg[30:0], 24'd0}) + pl_reg;
        tu_round  = tu + (64'd1 << 26);
        y_sum     = 54'(x_reg) + 54'(bq_reg[0]);
        st0_next  = 54'(x_reg) + 54'(x_reg) - 54'(q1_reg) + 54'(bq_reg[1]);
        st1_next  = 54'(x_reg) - 54'(q2_reg);
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_FIR:
            begin
                if (st1_act && rd_ok_reg)
                begin
                    mul_a = MUL_W'(mag_of(rdata));
                    mul_b = MUL_W'(hen_tap(tap_idx));
                end
            end
            S_SQD:
            begin
                mul_a = MUL_W'(mag_of(dly_reg));
                mul_b = MUL_W'(mag_of(dly_reg));
            end
            S_SQC:
            begin
                mul_a = MUL_W'(conv_reg);
                mul_b = MUL_W'(conv_reg);
            end
            S_GAIN:
            begin
                mul_a = MUL_W'(sq_r_reg[31:0]);
                mul_b = MUL_W'(GAIN_Q60);
            end
            S_BM1:
            begin
                mul_a = MUL_W'(ay[23:0]);
                mul_b = MUL_W'(a1_mag);
            end
            S_BM2:
            begin
                mul_a = MUL_W'(ay[47:24]);
                mul_b = MUL_W'(a1_mag);
            end
            S_BM3:
            begin
                mul_a = MUL_W'(ay[23:0]);
                mul_b = MUL_W'(a2_mag);
            end
            S_BM4:
            begin
                mul_a = MUL_W'(ay[47:24]);
                mul_b = MUL_W'(a2_mag);
            end
            S_O1:
            begin
                mul_a = MUL_W'(ay[23:0]);
                mul_b = MUL_W'(gain_reg);
            end
            S_O2:
            begin
                mul_a = MUL_W'(ay[47:24]);
                mul_b = MUL_W'(gain_reg);
            end
            S_O5:
            begin
                mul_a = MUL_W'(t_reg[23:0]);
                mul_b = MUL_W'(noise_mag);
            end
            S_O6:
            begin
                mul_a = MUL_W'(t_reg[38:24]);
                mul_b = MUL_W'(noise_mag);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= GAIN_RESET;
            env_only_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OUTPUT_GAIN: gain_reg     <= cfg_data[15:0];
                REG_ENV_MODE:    env_only_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ok_reg <= ({1'b0, age} < FILL_W'(fill_reg));
        tneg_reg  <= rdata[SB-1] ^ ~j1[ADDR_W-1];
        if (state_reg == S_FIR && cnt_reg == CNT_W'(TAPS + 1))
        begin
            dly_reg <= rd_ok_reg ? rdata : '0;
        end
        if (in_xfer)
        begin
            noise_reg <= noise_in;
            cur_reg   <= wp_reg;
        end
        case (state_reg)
            S_SQD:
            begin
                conv_reg <= 32'((acc_mag + ACC_W'(1 << (CONV_SHIFT - 1))) >> CONV_SHIFT);
            end
            S_SQC:
            begin
                sqa_reg <= prod_reg[63:0] << DLY_SHIFT;
            end
            S_SQS:
            begin
                sq_v_reg <= sqa_reg + prod_reg[63:0];
                sq_r_reg <= '0;
                bit_reg  <= 64'd1 << 62;
            end
            S_SQRT:
            begin
                if (sq_v_reg >= trial)
                begin
                    sq_v_reg <= sq_v_reg - trial;
                    sq_r_reg <= (sq_r_reg >> 1) + bit_reg;
                end
                else
                begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            S_GX:
            begin
                x_reg <= BQ_W'((prod_reg + (PROD_W'(1) << 43)) >> 44);
            end
            S_BY:
            begin
                y_reg <= sat48(y_sum);
            end
            S_BM2, S_BM4, S_O2, S_O6:
            begin
                pl_reg <= prod_reg[63:0];
            end
            S_BM3:
            begin
                q1_reg <= (a1[31] ^ y_neg) ? -$signed({1'b0, q_mag[50:0]})
                                           : $signed({1'b0, q_mag[50:0]});
            end
            S_BM5:
            begin
                q2_reg <= (a2[31] ^ y_neg) ? -$signed({1'b0, q_mag[50:0]})
                                           : $signed({1'b0, q_mag[50:0]});
            end
            S_BUPD:
            begin
                x_reg <= y_reg;
            end
            S_O3:
            begin
                m_reg <= {prod_reg[39:0], 24'd0} + pl_reg;
            end
            S_O4:
            begin
                t_reg   <= t_round[63:25];
                res_reg <= sat_out(y_neg, 64'(env_round >> ENV_SHIFT));
            end
            S_O7:
            begin
                res_reg <= sat_out(y_neg ^ noise_reg[SB-1], tu_round >> 27);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            s2_reg        <= 1'b0;
            acc_reg       <= '0;
            sec_reg       <= '0;
            out_valid_reg <= 1'b0;
            audio_out_reg <= '0;
            for (int i = 0; i < BQ_N; i++)
            begin
                bq_reg[i] <= '0;
            end
        end
        else
        begin
            s2_reg <= st1_act;
            if (s2_reg)
            begin
                acc_reg <= tneg_reg ? acc_reg - ACC_W'(prod_reg)
                                    : acc_reg + ACC_W'(prod_reg);
            end
            if (out_xfer && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        wp_reg  <= wp_reg + ADDR_W'(1);
                        acc_reg <= '0;
                        cnt_reg <= '0;
                        if (fill_reg != FILL_W'(TAPS))
                        begin
                            fill_reg <= fill_reg + FILL_W'(1);
                        end
                        state_reg <= S_FIR;
                    end
                end
                S_FIR:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(TAPS + 1))
                    begin
                        state_reg <= S_SQD;
                    end
                end
                S_SQD:  state_reg <= S_SQC;
                S_SQC:  state_reg <= S_SQS;
                S_SQS:  state_reg <= S_SQRT;
                S_SQRT:
                begin
                    if (bit_reg[0])
                    begin
                        state_reg <= S_GAIN;
                    end
                end
                S_GAIN:
                begin
                    sec_reg   <= '0;
                    state_reg <= S_GX;
                end
                S_GX:   state_reg <= S_BY;
                S_BY:   state_reg <= S_BM1;
                S_BM1:  state_reg <= S_BM2;
                S_BM2:  state_reg <= S_BM3;
                S_BM3:  state_reg <= S_BM4;
                S_BM4:  state_reg <= S_BM5;
                S_BM5:  state_reg <= S_BUPD;
                S_BUPD:
                begin
                    for (int i = 0; i < BQ_N - 2; i++)
                    begin
                        bq_reg[i] <= bq_reg[i+2];
                    end
                    bq_reg[BQ_N-2] <= sat48(st0_next);
                    bq_reg[BQ_N-1] <= sat48(st1_next);
                    if (sec_reg == SEC_W'(SECTIONS - 1))
                    begin
                        state_reg <= S_O1;
                    end
                    else
                    begin
                        sec_reg   <= sec_reg + SEC_W'(1);
                        state_reg <= S_BY;
                    end
                end
                S_O1:   state_reg <= S_O2;
                S_O2:   state_reg <= S_O3;
                S_O3:   state_reg <= S_O4;
                S_O4:   state_reg <= env_only_reg ? S_OUT : S_O5;
                S_O5:   state_reg <= S_O6;
                S_O6:   state_reg <= S_O7;
                S_O7:   state_reg <= S_OUT;
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        audio_out_reg <= res_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_accept_starts_fir: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == S_FIR)
        else $error("accepted transfer did not start the filter pass");

    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("output valid raised outside the output state");

    a_sqrt_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SQRT |-> $onehot(bit_reg))
        else $error("square root bit is not one-hot");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && out_valid_reg && out_stall |=> state_reg == S_OUT)
        else $error("result left the output state while the register was full");

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps

class envelope_scoreboard;
    bit signed [63:0] window [128];
    bit signed [63:0] qdelay [63];
    bit signed [63:0] bq [2][2];
    bit [15:0] gain;
    bit env_only;
    logic signed [15:0] pending [$];
    int mismatches;
    int checked;

    function new();
        foreach (window[i]) window[i] = 0;
        foreach (qdelay[i]) qdelay[i] = 0;
        foreach (bq[i, j]) bq[i][j] = 0;
        gain = hen_pkg::GAIN_RESET;
        env_only = 0;
        mismatches = 0;
        checked = 0;
    endfunction

    function void set_reg(bit idx, bit [15:0] val);
        if (idx == hen_pkg::REG_OUTPUT_GAIN) gain = val;
        else env_only = val[0];
    endfunction

    function bit signed [63:0] rnd(bit signed [63:0] v, int s);
        bit [63:0] half;
        half = 64'd1 << (s - 1);
        if (v < 0) return -$signed((64'(-v) + half) >> s);
        return $signed((64'(v) + half) >> s);
    endfunction

    function bit signed [63:0] sat48(bit signed [63:0] v);
        if (v > (64'sd1 <<< 47) - 1) return (64'sd1 <<< 47) - 1;
        if (v < -(64'sd1 <<< 47)) return -(64'sd1 <<< 47);
        return v;
    endfunction

    function bit signed [63:0] tap(int j);
        int k;
        bit signed [63:0] t;
        k = (j < 64) ? j : 127 - j;
        t = hen_pkg::hen_tap(6'(k));
        return (j < 64) ? t : -t;
    endfunction

    function bit [63:0] root(bit [63:0] v);
        bit [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function bit signed [63:0] mulq30(bit signed [63:0] a, bit signed [63:0] y);
        bit signed [127:0] p;
        bit [127:0] u;
        p = 128'(a) * 128'(y);
        u = (p < 0) ? -p : p;
        u = (u + (128'd1 << 29)) >> 30;
        return (p < 0) ? -$signed(64'(u)) : $signed(64'(u));
    endfunction

    function void note_input(logic signed [15:0] s, logic signed [15:0] n);
        bit signed [63:0] acc, conv, dl, x, y, res, c0, c1, na;
        bit [127:0] m, t, r, e;
        bit [63:0] env;
        for (int i = 0; i < 127; i++) window[i] = window[i + 1];
        window[127] = s;
        dl = qdelay[0];
        for (int i = 0; i < 62; i++) qdelay[i] = qdelay[i + 1];
        qdelay[62] = s;
        acc = 0;
        for (int j = 0; j < 128; j++) acc -= window[j] * tap(j);
        conv = rnd(acc, 8);
        dl = dl * 512;
        env = root(64'(conv * conv) + 64'(dl * dl));
        e = 128'(env) * 128'(hen_pkg::GAIN_Q60);
        x = sat48($signed(64'((e + (128'd1 << 43)) >> 44)));
        y = 0;
        for (int k = 0; k < 2; k++)
        begin
            c0 = hen_pkg::hen_fb(k[0], 1'b0);
            c1 = hen_pkg::hen_fb(k[0], 1'b1);
            y = sat48(x + bq[k][0]);
            bq[k][0] = sat48(2 * x - mulq30(c0, y) + bq[k][1]);
            bq[k][1] = sat48(x - mulq30(c1, y));
            x = y;
        end
        m = 128'((y < 0) ? -y : y) * gain;
        if (env_only) r = (m + (128'd1 << 36)) >> 37;
        else
        begin
            t = (m + (128'd1 << 24)) >> 25;
            na = (n < 0) ? -64'sd1 * n : n;
            r = (t * 128'(na) + (128'd1 << 26)) >> 27;
        end
        if ((y < 0) != (!env_only && n < 0))
            res = (r > 32768) ? -64'sd32768 : -$signed(64'(r));
        else
            res = (r > 32767) ? 64'sd32767 : $signed(64'(r));
        pending.push_back(16'(res));
    endfunction

    function void check_result(logic signed [15:0] got);
        logic signed [15:0] want;
        checked++;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected output %0d", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10) $display("audio_out mismatch: expected %0d, got %0d", want, got);
        end
    endfunction
endclass

module testbench;
    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [15:0] audio_in = 0;
    logic signed [15:0] noise_in = 0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [15:0] audio_out;
    logic cfg_we = 0;
    logic [hen_pkg::CFG_INDEX_W-1:0] cfg_index = hen_pkg::REG_OUTPUT_GAIN;
    logic [15:0] cfg_data = 0;
    envelope_scoreboard sb = new();
    int sent = 0;
    int stall_mode = 0;

    hilbert_envelope_noise_modulator dut (.*);

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check_result(audio_out);
        if (rst_n && in_valid && !in_stall)
        begin
            sb.note_input(audio_in, noise_in);
            sent++;
        end
    end

    always @(posedge clk)
    begin
        if (($urandom % 400) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 0;
            1: out_stall <= ($urandom % 3) == 0;
            default: out_stall <= ($urandom % 8) != 0;
        endcase
    end

    task automatic write_reg(logic [hen_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic send(logic signed [15:0] a, logic signed [15:0] n);
        in_valid <= 1;
        audio_in <= a;
        noise_in <= n;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_block(int count, int shape);
        int burst;
        logic signed [15:0] a;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                in_valid <= 0;
                repeat ($urandom_range(0, 300)) @(posedge clk);
                burst = $urandom_range(1, 40);
            end
            case (shape)
                0: a = 16'($urandom);
                1: a = ($urandom % 2) ? 16'sh7fff : 16'sh8000;
                default: a = 16'($signed(14'($urandom)));
            endcase
            send(a, 16'($urandom));
            burst--;
        end
        in_valid <= 0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send(16'sh7fff, 16'sh7fff);
        send(16'sh8000, 16'sh8000);
        send(16'sd0, 16'sd0);
        for (int i = 0; i < 12; i++) send(16'sh7fff, (i % 2) ? 16'sh8000 : 16'sh7fff);
        for (int i = 0; i < 10; i++) send(16'sh8000, 16'sh0001);
        in_valid <= 0;
        drain();
        write_reg(hen_pkg::REG_OUTPUT_GAIN, 16'hffff);
        write_reg(hen_pkg::REG_ENV_MODE, 16'd1);
        send_block(300, 1);
        drain();
        write_reg(hen_pkg::REG_OUTPUT_GAIN, 16'd0);
        send_block(100, 0);
        drain();
        write_reg(hen_pkg::REG_OUTPUT_GAIN, 16'($urandom));
        write_reg(hen_pkg::REG_ENV_MODE, 16'd0);
        send_block(400, 0);
        drain();
        write_reg(hen_pkg::REG_OUTPUT_GAIN, 16'hffff);
        send_block(350, 1);
        drain();
        write_reg(hen_pkg::REG_OUTPUT_GAIN, 16'h1000);
        write_reg(hen_pkg::REG_ENV_MODE, 16'd1);
        send_block(375, 2);
        drain();
        $display("Sent %0d samples and checked %0d outputs across gain and mode settings.",
            sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Timed out waiting for outputs.");
        $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: filelist.f
hdl/hen_pkg.sv
hdl/hen_ram.sv
hdl/hilbert_envelope_noise_modulator.sv
sim/testbench.sv
